[rtl/core/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 keystream cipher core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

    // Permutation geometry
    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned PERM_AW    = 8;

    // Item kind codes
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Last step index of the key schedule
    localparam logic [PERM_AW-1:0] SCHED_LAST = 8'hFF;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_J,
        ST_RD_T,
        ST_FIN,
        ST_SCH_INIT,
        ST_SCH_RK,
        ST_SCH_RJ,
        ST_SCH_WK,
        ST_SCH_WJ
    } state_t;

    // Request bundle into the permutation memory
    typedef struct packed {
        logic               clr;
        logic               re;
        logic [PERM_AW-1:0] raddr;
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [7:0]         wdata;
    } sbox_req_t;

endpackage : rc4_pkg

`default_nettype wire

[rtl/core/rc4_sbox.sv]
// ----------------------------------------------------------------------------
// rc4_sbox
// Permutation memory: one write and one read port, registered read data,
// write-first bypass, and per-entry valid bits so that an unwritten entry
// reads as its own index (identity). A clear request restores identity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_sbox
    import rc4_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire sbox_req_t  req,
    output logic [7:0]      rdata
);

    logic [7:0]            mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] valid_reg;
    logic [7:0]            rdata_reg;

    // Store write data
    always_ff @(posedge clk)
    begin
        if (req.we && !req.clr)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Track written entries; clear restores identity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clr)
        begin
            valid_reg <= '0;
        end
        else if (req.we)
        begin
            valid_reg[req.waddr] <= 1'b1;
        end
    end

    // Read with write-first bypass; hold data when no read is issued
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            if (req.we && (req.waddr == req.raddr))
            begin
                rdata_reg <= req.wdata;
            end
            else if (valid_reg[req.raddr])
            begin
                rdata_reg <= mem[req.raddr];
            end
            else
            begin
                rdata_reg <= req.raddr;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule : rc4_sbox

`default_nettype wire

[rtl/core/rc4_key_store.sv]
// ----------------------------------------------------------------------------
// rc4_key_store
// Key byte memory with fill counter. Bytes beyond the capacity are dropped.
// Registered read port for the key schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_key_store
    import rc4_pkg::*;
#(
    parameter int unsigned KEY_BYTES_MAX = 256,
    parameter int unsigned KAW           = 8,
    parameter int unsigned LW            = 9
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire logic [7:0]     wdata,
    input  wire logic           clr_len,
    input  wire logic           rd,
    input  wire logic [KAW-1:0] raddr,
    output logic [7:0]          rdata,
    output logic [LW-1:0]       len
);

    logic [7:0]    mem [KEY_BYTES_MAX];
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [7:0]    rdata_reg;
    logic          full;

    assign full = (len_reg == LW'(KEY_BYTES_MAX));

    // Append key byte while room remains
    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem[len_reg[KAW-1:0]] <= wdata;
        end
    end

    // Read key byte for the schedule
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Advance or drop fill count
    always_comb
    begin
        len_next = len_reg;
        if (clr_len)
        begin
            len_next = '0;
        end
        else if (wr && !full)
        begin
            len_next = len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    assign rdata = rdata_reg;
    assign len   = len_reg;

endmodule : rc4_key_store

`default_nettype wire

[rtl/core/rc4_keystream_cipher.sv]
// ----------------------------------------------------------------------------
// rc4_keystream_cipher
// Byte-wide RC4 core: key loading, key schedule and keystream XOR around
// one permutation memory and one key memory.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_stall  | kind, data_byte, last_key
//  output   | out_valid / out_stall| out_byte
//
//  A data byte steps through read S[i], read S[j], swap and read S[t],
//  each step waiting on the registered read data of the permutation memory.
//  A key byte is stored as it is accepted. A marked last key byte runs the
//  schedule: restore identity, then per step read S[k] and S[j], write both.
//  Reset gives identity permutation, zero indices and an empty key store.
//  A stalled output holds the sequencer in its final data step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rc4_keystream_cipher
    import rc4_pkg::*;
#(
    parameter int unsigned KEY_BYTES_MAX = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       kind,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_key,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte
);

    localparam int unsigned KAW = (KEY_BYTES_MAX > 1) ? $clog2(KEY_BYTES_MAX) : 1;
    localparam int unsigned LW  = $clog2(KEY_BYTES_MAX + 1);

    state_t             state_reg, state_next;
    logic [PERM_AW-1:0] a_reg, a_next;
    logic [PERM_AW-1:0] b_reg, b_next;
    logic [7:0]         sa_reg, sa_next;
    logic [PERM_AW-1:0] t_reg, t_next;
    logic [7:0]         byte_reg, byte_next;
    logic [KAW-1:0]     kidx_reg, kidx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;

    sbox_req_t          sreq;
    logic [7:0]         s_rdata;
    logic               key_wr;
    logic               key_clr;
    logic               key_rd;
    logic [7:0]         key_rdata;
    logic [LW-1:0]      key_len;

    logic               out_free;
    logic               in_take;
    logic [LW-1:0]      kidx_inc;
    logic [7:0]         ks;

    rc4_sbox u_sbox
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rdata (s_rdata)
    );

    rc4_key_store
    #(
        .KEY_BYTES_MAX (KEY_BYTES_MAX),
        .KAW           (KAW),
        .LW            (LW)
    )
    u_key
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (key_wr),
        .wdata   (data_byte),
        .clr_len (key_clr),
        .rd      (key_rd),
        .raddr   (kidx_reg),
        .rdata   (key_rdata),
        .len     (key_len)
    );

    // Handshake: accept when idle or when the last data step can retire
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_FIN) && out_free));
    assign in_take  = in_valid && !in_stall;

    // Keystream byte, fixed up when t hits the entry written last
    assign ks       = (t_reg == b_reg) ? sa_reg : s_rdata;
    assign kidx_inc = LW'(kidx_reg) + LW'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_FIN:
            begin
                if ((state_reg == ST_FIN) && !out_free)
                begin
                    state_next = ST_FIN;
                end
                else if (in_take && (kind == KIND_DATA))
                begin
                    state_next = ST_RD_J;
                end
                else if (in_take && last_key)
                begin
                    state_next = ST_SCH_INIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_J:     state_next = ST_RD_T;
            ST_RD_T:     state_next = ST_FIN;
            ST_SCH_INIT: state_next = ST_SCH_RK;
            ST_SCH_RK:   state_next = ST_SCH_RJ;
            ST_SCH_RJ:   state_next = ST_SCH_WK;
            ST_SCH_WK:   state_next = ST_SCH_WJ;
            ST_SCH_WJ:   state_next = (a_reg == SCHED_LAST) ? ST_IDLE : ST_SCH_RK;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb
    begin
        a_next         = a_reg;
        b_next         = b_reg;
        sa_next        = sa_reg;
        t_next         = t_reg;
        byte_next      = byte_reg;
        kidx_next      = kidx_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && out_stall;
        sreq           = '0;
        key_wr         = 1'b0;
        key_clr        = 1'b0;
        key_rd         = 1'b0;

        unique case (state_reg)
            ST_IDLE, ST_FIN:
            begin
                // Retire data transaction: second swap write, load result
                if (state_reg == ST_FIN)
                begin
                    sreq.we   = 1'b1;
                    sreq.waddr = b_reg;
                    sreq.wdata = sa_reg;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = byte_reg ^ ks;
                    end
                end
                // Start next transaction
                if (in_take)
                begin
                    if (kind == KIND_DATA)
                    begin
                        a_next     = a_reg + PERM_AW'(1);
                        byte_next  = data_byte;
                        sreq.re    = 1'b1;
                        sreq.raddr = a_reg + PERM_AW'(1);
                    end
                    else
                    begin
                        key_wr = 1'b1;
                    end
                end
            end
            ST_RD_J:
            begin
                // S[i] arrives: advance j, read S[j]
                sa_next    = s_rdata;
                b_next     = b_reg + s_rdata;
                sreq.re    = 1'b1;
                sreq.raddr = b_reg + s_rdata;
            end
            ST_RD_T:
            begin
                // S[j] arrives: write S[i], read S[t]
                sreq.we    = 1'b1;
                sreq.waddr = a_reg;
                sreq.wdata = s_rdata;
                t_next     = sa_reg + s_rdata;
                sreq.re    = 1'b1;
                sreq.raddr = sa_reg + s_rdata;
            end
            ST_SCH_INIT:
            begin
                // Restore identity and clear counters
                sreq.clr  = 1'b1;
                a_next    = '0;
                b_next    = '0;
                kidx_next = '0;
            end
            ST_SCH_RK:
            begin
                // Read S[k] and the key byte, wrap key index at length
                sreq.re    = 1'b1;
                sreq.raddr = a_reg;
                key_rd     = 1'b1;
                kidx_next  = (kidx_inc == key_len) ? '0 : kidx_inc[KAW-1:0];
            end
            ST_SCH_RJ:
            begin
                // Mix into j, read S[j]
                sa_next    = s_rdata;
                b_next     = b_reg + s_rdata + key_rdata;
                sreq.re    = 1'b1;
                sreq.raddr = b_reg + s_rdata + key_rdata;
            end
            ST_SCH_WK:
            begin
                sreq.we    = 1'b1;
                sreq.waddr = a_reg;
                sreq.wdata = s_rdata;
            end
            ST_SCH_WJ:
            begin
                sreq.we    = 1'b1;
                sreq.waddr = b_reg;
                sreq.wdata = sa_reg;
                a_next     = a_reg + PERM_AW'(1);
                if (a_reg == SCHED_LAST)
                begin
                    b_next  = '0;
                    key_clr = 1'b1;
                end
            end
            default:
            begin
                sreq = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            kidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            kidx_reg      <= kidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sa_reg       <= sa_next;
        t_reg        <= t_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule : rc4_keystream_cipher

`default_nettype wire
